@@ rtl/fpdbs_pkg.sv @@
`default_nettype none
package fpdbs_pkg;

  // Default width of the saturating tick counters (legal range 16 to 64)
  localparam int COUNT_BITS_DEFAULT = 32;

  // Configuration port
  localparam int CFG_DATA_W  = 32;
  localparam int CFG_INDEX_W = 3;
  localparam int PERIOD_W    = 30;
  localparam int STARV_W     = 32;

  localparam logic [CFG_INDEX_W-1:0] REG_ENABLED        = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SOURCE         = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_FORCE_PATTERN  = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_SELECT = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_PERIOD_TICKS   = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_STARV_TICKS    = 3'd5;

  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 30'd16000;
  localparam logic [STARV_W-1:0]  STARV_RESET  = 32'd100000;

  // Frame sources (code three behaves as idle)
  localparam logic [1:0] SRC_IDLE    = 2'd0;
  localparam logic [1:0] SRC_STREAM  = 2'd1;
  localparam logic [1:0] SRC_PATTERN = 2'd2;

  // Item operations
  localparam logic OP_TICK   = 1'b0;
  localparam logic OP_SUBMIT = 1'b1;

  // Test patterns
  localparam logic PAT_BLACK = 1'b0;
  localparam logic PAT_GRID  = 1'b1;

  // Held pattern: none, else pattern + 1
  localparam logic [1:0] HELD_NONE = 2'd0;

  // Finish codes
  localparam logic [1:0] FIN_NONE = 2'd0;
  localparam logic [1:0] FIN_DONE = 2'd1;
  localparam logic [1:0] FIN_DROP = 2'd2;

endpackage
`default_nettype wire

@@ rtl/fpdbs_if.sv @@
`default_nettype none
// Input item channel
interface fpdbs_in_if;
  logic valid;
  logic ready;
  logic operation;
  logic dma_done;
  logic fifo_empty;
  logic build_ok;

  modport source (output valid, output operation, output dma_done,
                  output fifo_empty, output build_ok, input ready);
  modport sink   (input valid, input operation, input dma_done,
                  input fifo_empty, input build_ok, output ready);
endinterface

// Result item channel
interface fpdbs_out_if;
  logic       valid;
  logic       ready;
  logic       start_tx;
  logic       tx_buffer;
  logic       build_buffer;
  logic [1:0] finish;
  logic       late_start;
  logic       frame_repeated;
  logic       frame_superseded;
  logic       starvation_event;
  logic       starved;
  logic       idle_period;
  logic       build_rejected;
  logic       needs_frame;

  modport source (output valid, output start_tx, output tx_buffer, output build_buffer,
                  output finish, output late_start, output frame_repeated,
                  output frame_superseded, output starvation_event, output starved,
                  output idle_period, output build_rejected, output needs_frame,
                  input ready);
  modport sink   (input valid, input start_tx, input tx_buffer, input build_buffer,
                  input finish, input late_start, input frame_repeated,
                  input frame_superseded, input starvation_event, input starved,
                  input idle_period, input build_rejected, input needs_frame,
                  output ready);
endinterface
`default_nettype wire

@@ rtl/frame_pacing_double_buffer_scheduler_core.sv @@
`default_nettype none
// Channel     Dir  Handshake     Payload
// item_in     in   valid/ready   operation, dma_done, fifo_empty, build_ok
// result_out  out  valid/ready   start_tx .. needs_frame (one result per item)
// cfg         in   cfg_we only   cfg_index, cfg_data (no read-back)
//
// Throughput: one item per cycle while result_out is not stalled; an item passes the
// input register, then the scheduler step is computed into the result register.
// The per-item path is one counter increment and a 32+ bit compare per counter.
// Stalls: result_out.ready low holds the result; one more item waits in the
// input register, then item_in.ready drops.
// Reset (rst, sync, active high): config to defaults, all state and counters cleared.
module frame_pacing_double_buffer_scheduler_core
  import fpdbs_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEFAULT
) (
  input  wire                   clk,
  input  wire                   rst,
  fpdbs_in_if.sink              item_in,
  fpdbs_out_if.source           result_out,
  input  wire                   cfg_we,
  input  wire [CFG_INDEX_W-1:0] cfg_index,
  input  wire [CFG_DATA_W-1:0]  cfg_data
);

  // compare width: covers the counters and 4x period
  localparam int CW = (COUNT_BITS > STARV_W) ? COUNT_BITS : STARV_W;

  // configuration
  logic                enabled;
  logic [1:0]          source;
  logic                force_pattern;
  logic                pattern_select;
  logic [PERIOD_W-1:0] period_ticks;
  logic [STARV_W-1:0]  starvation_ticks;

  // scheduler state
  logic                  ready_index, sending_index, have_frame, fresh_frame, busy;
  logic [1:0]            pattern_held;
  logic                  starved_flag;
  logic [COUNT_BITS-1:0] since_period_start, since_tx_start, since_submit;

  // input register
  logic s1_valid;
  logic s1_op, s1_dma, s1_fifo, s1_ok;
  logic adv;

  // result register
  logic       out_valid;
  logic       r_start, r_txb, r_bb, r_late, r_rep, r_sup, r_sev, r_stv, r_idle, r_rej, r_need;
  logic [1:0] r_fin;

  // step results
  logic                  ready_index_next, sending_index_next, have_frame_next;
  logic                  fresh_frame_next, busy_next, starved_flag_next;
  logic [1:0]            pattern_held_next;
  logic [COUNT_BITS-1:0] since_period_start_next, since_tx_start_next, since_submit_next;
  logic                  o_start, o_bb, o_late, o_rep, o_sup, o_sev, o_idle, o_rej;
  logic [1:0]            o_fin;

  assign adv           = s1_valid && (!out_valid || result_out.ready);
  assign item_in.ready = !s1_valid || adv;

  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
    return (&v) ? v : v + COUNT_BITS'(1);
  endfunction

  always_comb begin
    logic [1:0] src;
    logic       do_build;
    logic       pat;
    logic       idx;

    ready_index_next        = ready_index;
    sending_index_next      = sending_index;
    have_frame_next         = have_frame;
    fresh_frame_next        = fresh_frame;
    busy_next               = busy;
    pattern_held_next       = pattern_held;
    starved_flag_next       = starved_flag;
    since_period_start_next = since_period_start;
    since_tx_start_next     = since_tx_start;
    since_submit_next       = since_submit;
    o_start = 1'b0; o_bb = 1'b0; o_late = 1'b0; o_rep = 1'b0; o_sup = 1'b0;
    o_sev = 1'b0; o_idle = 1'b0; o_rej = 1'b0; o_fin = FIN_NONE;
    src = SRC_IDLE; do_build = 1'b0; pat = PAT_BLACK; idx = 1'b0;

    if (!enabled) begin
      o_rej = (s1_op == OP_SUBMIT);
    end else if (s1_op == OP_SUBMIT) begin
      // build into the buffer not being read
      idx  = busy ? ~sending_index : ~ready_index;
      o_bb = idx;
      if (!s1_ok) begin
        o_rej = 1'b1;
      end else begin
        pattern_held_next = HELD_NONE;
        since_submit_next = '0;
        starved_flag_next = 1'b0;
        o_sup             = fresh_frame && have_frame;
        ready_index_next  = idx;
        have_frame_next   = 1'b1;
        fresh_frame_next  = 1'b1;
      end
    end else begin
      since_period_start_next = sat_inc(since_period_start);
      since_tx_start_next     = sat_inc(since_tx_start);
      since_submit_next       = sat_inc(since_submit);

      // end of the running transfer: done, or stalled past 4 periods
      if (busy) begin
        if (s1_dma && s1_fifo) begin
          busy_next = 1'b0;
          o_fin     = FIN_DONE;
        end else if (CW'(since_tx_start_next) > CW'({period_ticks, 2'b00})) begin
          busy_next = 1'b0;
          o_fin     = FIN_DROP;
        end
      end

      if (CW'(since_period_start_next) >= CW'(period_ticks)) begin
        src = force_pattern ? SRC_PATTERN : source;
        if (src == SRC_PATTERN) begin
          do_build = 1'b1;
          pat      = pattern_select;
        end else if (src == SRC_STREAM &&
                     (!have_frame_next || CW'(since_submit_next) > CW'(starvation_ticks))) begin
          // starved: fall back to black
          if (!starved_flag_next) begin
            starved_flag_next = 1'b1;
            o_sev             = 1'b1;
          end
          do_build = 1'b1;
          pat      = PAT_BLACK;
        end

        if (do_build) begin
          if (pattern_held_next == {1'b0, pat} + 2'd1) begin
            fresh_frame_next = 1'b1;   // already in a buffer
          end else begin
            idx  = busy_next ? ~sending_index_next : ~ready_index_next;
            o_bb = idx;
            if (!s1_ok) begin
              o_rej = 1'b1;
            end else begin
              pattern_held_next = {1'b0, pat} + 2'd1;
              o_sup             = fresh_frame_next && have_frame_next;
              ready_index_next  = idx;
              have_frame_next   = 1'b1;
              fresh_frame_next  = 1'b1;
            end
          end
        end

        if (src != SRC_STREAM && src != SRC_PATTERN) begin
          o_idle                  = 1'b1;
          since_period_start_next = '0;
        end else if (busy_next) begin
          o_late = 1'b1;
        end else if (!have_frame_next) begin
          o_idle                  = 1'b1;
          since_period_start_next = '0;
        end else begin
          sending_index_next      = ready_index_next;
          since_tx_start_next     = '0;
          since_period_start_next = '0;
          busy_next               = 1'b1;
          o_rep                   = !fresh_frame_next;
          fresh_frame_next        = 1'b0;
          o_start                 = 1'b1;
        end
      end
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item_in.ready) begin
      s1_valid <= item_in.valid;
    end
    if (item_in.valid && item_in.ready) begin
      s1_op   <= item_in.operation;
      s1_dma  <= item_in.dma_done;
      s1_fifo <= item_in.fifo_empty;
      s1_ok   <= item_in.build_ok;
    end
  end

  // configuration and scheduler state
  always_ff @(posedge clk) begin
    if (rst) begin
      enabled            <= 1'b0;
      source             <= SRC_IDLE;
      force_pattern      <= 1'b0;
      pattern_select     <= PAT_BLACK;
      period_ticks       <= PERIOD_RESET;
      starvation_ticks   <= STARV_RESET;
      ready_index        <= 1'b0;
      sending_index      <= 1'b0;
      have_frame         <= 1'b0;
      fresh_frame        <= 1'b0;
      busy               <= 1'b0;
      pattern_held       <= HELD_NONE;
      starved_flag       <= 1'b0;
      since_period_start <= '0;
      since_tx_start     <= '0;
      since_submit       <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ENABLED: begin
          if (cfg_data[0] && !enabled) begin
            // re-arm
            enabled            <= 1'b1;
            ready_index        <= 1'b0;
            sending_index      <= 1'b0;
            have_frame         <= 1'b0;
            fresh_frame        <= 1'b0;
            busy               <= 1'b0;
            pattern_held       <= HELD_NONE;
            starved_flag       <= 1'b0;
            since_period_start <= '0;
            since_tx_start     <= '0;
            since_submit       <= '0;
          end else if (!cfg_data[0] && enabled) begin
            enabled     <= 1'b0;
            busy        <= 1'b0;
            have_frame  <= 1'b0;
            fresh_frame <= 1'b0;
            source      <= SRC_IDLE;
          end
        end
        REG_SOURCE:         source           <= cfg_data[1:0];
        REG_FORCE_PATTERN:  force_pattern    <= cfg_data[0];
        REG_PATTERN_SELECT: pattern_select   <= cfg_data[0];
        REG_PERIOD_TICKS:   period_ticks     <= cfg_data[PERIOD_W-1:0];
        REG_STARV_TICKS:    starvation_ticks <= cfg_data[STARV_W-1:0];
        default: ;
      endcase
    end else if (adv) begin
      ready_index        <= ready_index_next;
      sending_index      <= sending_index_next;
      have_frame         <= have_frame_next;
      fresh_frame        <= fresh_frame_next;
      busy               <= busy_next;
      pattern_held       <= pattern_held_next;
      starved_flag       <= starved_flag_next;
      since_period_start <= since_period_start_next;
      since_tx_start     <= since_tx_start_next;
      since_submit       <= since_submit_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= 1'b1;
    end else if (result_out.ready) begin
      out_valid <= 1'b0;
    end
    if (adv) begin
      r_start <= o_start;
      r_txb   <= sending_index_next;
      r_bb    <= o_bb;
      r_fin   <= o_fin;
      r_late  <= o_late;
      r_rep   <= o_rep;
      r_sup   <= o_sup;
      r_sev   <= o_sev;
      r_stv   <= starved_flag_next;
      r_idle  <= o_idle;
      r_rej   <= o_rej;
      r_need  <= enabled && !fresh_frame_next;
    end
  end

  assign result_out.valid            = out_valid;
  assign result_out.start_tx         = r_start;
  assign result_out.tx_buffer        = r_txb;
  assign result_out.build_buffer     = r_bb;
  assign result_out.finish           = r_fin;
  assign result_out.late_start       = r_late;
  assign result_out.frame_repeated   = r_rep;
  assign result_out.frame_superseded = r_sup;
  assign result_out.starvation_event = r_sev;
  assign result_out.starved          = r_stv;
  assign result_out.idle_period      = r_idle;
  assign result_out.build_rejected   = r_rej;
  assign result_out.needs_frame      = r_need;

endmodule
`default_nettype wire

@@ rtl/fpdbs_checker.sv @@
`default_nettype none
module fpdbs_checker
  import fpdbs_pkg::*;
(
  input wire       clk,
  input wire       rst,
  input wire       out_valid,
  input wire       out_ready,
  input wire       start_tx,
  input wire       tx_buffer,
  input wire [1:0] finish,
  input wire       late_start,
  input wire       starvation_event,
  input wire       starved,
  input wire       idle_period
);

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable({start_tx, tx_buffer, finish}))
    else $error("result changed while stalled");

  // a started period is neither late nor idle
  a_start_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid && start_tx |-> !late_start && !idle_period)
    else $error("start together with late or idle");

  a_starve: assert property (@(posedge clk) disable iff (rst)
    out_valid && starvation_event |-> starved)
    else $error("starvation event without starved flag");

  a_finish: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> finish == FIN_NONE || finish == FIN_DONE || finish == FIN_DROP)
    else $error("bad finish code");

  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind frame_pacing_double_buffer_scheduler_core fpdbs_checker u_fpdbs_checker (
  .clk              (clk),
  .rst              (rst),
  .out_valid        (result_out.valid),
  .out_ready        (result_out.ready),
  .start_tx         (result_out.start_tx),
  .tx_buffer        (result_out.tx_buffer),
  .finish           (result_out.finish),
  .late_start       (result_out.late_start),
  .starvation_event (result_out.starvation_event),
  .starved          (result_out.starved),
  .idle_period      (result_out.idle_period)
);
`default_nettype wire

@@ tb/tb.sv @@
`timescale 1ns / 100ps

module tb;
  import fpdbs_pkg::*;

  localparam int         COUNT_BITS    = COUNT_BITS_DEFAULT;
  localparam int         SETTLE_CYCLES = 4;      // extra wait after the last owed result is back
  localparam int         LONG_HOLD     = 400;    // receiver hold-off, in cycles
  localparam int         STALL_LIMIT   = 4000;   // cycles with no handshake at all
  localparam int         N_PHASES      = 13;
  localparam logic [1:0] SRC_UNUSED    = 2'd3;   // behaves as idle

  typedef struct packed {
    logic operation;
    logic dma_done;
    logic fifo_empty;
    logic build_ok;
  } pacing_item_t;

  typedef struct packed {
    logic       start_tx;
    logic       tx_buffer;
    logic       build_buffer;
    logic [1:0] finish;
    logic       late_start;
    logic       frame_repeated;
    logic       frame_superseded;
    logic       starvation_event;
    logic       starved;
    logic       idle_period;
    logic       build_rejected;
    logic       needs_frame;
  } pacing_result_t;

  // Scheduler predictor plus the queue of results it still owes
  class pacing_scoreboard;
    logic                  en;
    logic [1:0]            src_sel;
    logic                  force_pat;
    logic                  pat_sel;
    logic [PERIOD_W-1:0]   period;
    logic [STARV_W-1:0]    starve_limit;

    logic                  ready_idx, send_idx, have_frame, fresh, busy, starved_flag;
    logic [1:0]            held;
    logic [COUNT_BITS-1:0] since_period, since_tx, since_submit;

    pacing_result_t        cur;
    pacing_result_t        expected_results[$];
    int                    errors, n_items, n_results, n_starts, n_drops, n_late, n_starve;

    function new();
      en           = 1'b0;
      src_sel      = SRC_IDLE;
      force_pat    = 1'b0;
      pat_sel      = PAT_BLACK;
      period       = PERIOD_RESET;
      starve_limit = STARV_RESET;
      rearm();
    endfunction

    function void rearm();
      have_frame   = 1'b0;
      fresh        = 1'b0;
      busy         = 1'b0;
      ready_idx    = 1'b0;
      send_idx     = 1'b0;
      held         = HELD_NONE;
      starved_flag = 1'b0;
      since_period = '0;
      since_tx     = '0;
      since_submit = '0;
    endfunction

    function void write_register(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_ENABLED: begin
          if (data[0] && !en) begin
            rearm();
            en = 1'b1;
          end else if (!data[0] && en) begin
            busy       = 1'b0;
            have_frame = 1'b0;
            fresh      = 1'b0;
            src_sel    = SRC_IDLE;
            en         = 1'b0;
          end
        end
        REG_SOURCE:         src_sel      = data[1:0];
        REG_FORCE_PATTERN:  force_pat    = data[0];
        REG_PATTERN_SELECT: pat_sel      = data[0];
        REG_PERIOD_TICKS:   period       = data[PERIOD_W-1:0];
        REG_STARV_TICKS:    starve_limit = data[STARV_W-1:0];
        default: ;
      endcase
    endfunction

    function logic [COUNT_BITS-1:0] bump(logic [COUNT_BITS-1:0] v);
      return (v == '1) ? v : v + COUNT_BITS'(1);
    endfunction

    // Build side: the buffer not being read
    function logic build_target();
      return busy ? ~send_idx : ~ready_idx;
    endfunction

    function void post_frame(logic idx);
      if (fresh && have_frame) cur.frame_superseded = 1'b1;
      ready_idx  = idx;
      have_frame = 1'b1;
      fresh      = 1'b1;
    endfunction

    // A pattern already in a buffer is just marked fresh again
    function void build_pattern(logic pat, logic ok);
      logic [1:0] code;
      logic       idx;
      code = {1'b0, pat} + 2'd1;
      if (held == code) begin
        fresh = 1'b1;
        return;
      end
      idx              = build_target();
      cur.build_buffer = idx;
      if (!ok) begin
        cur.build_rejected = 1'b1;
        return;
      end
      held = code;
      post_frame(idx);
    endfunction

    function void predict_item(pacing_item_t it);
      logic [1:0]  src;
      logic [63:0] stall_lim, cnt, slim;
      logic        idx;
      cur = '0;
      n_items++;
      if (!en) begin
        if (it.operation == OP_SUBMIT) cur.build_rejected = 1'b1;
      end else if (it.operation == OP_SUBMIT) begin
        idx              = build_target();
        cur.build_buffer = idx;
        if (!it.build_ok) begin
          cur.build_rejected = 1'b1;
        end else begin
          held         = HELD_NONE;
          since_submit = '0;
          starved_flag = 1'b0;
          post_frame(idx);
        end
      end else begin
        since_period = bump(since_period);
        since_tx     = bump(since_tx);
        since_submit = bump(since_submit);

        // transfer ends: done, or dropped after four periods
        stall_lim = 64'(period);
        stall_lim = stall_lim << 2;
        cnt       = 64'(since_tx);
        if (busy) begin
          if (it.dma_done && it.fifo_empty) begin
            busy       = 1'b0;
            cur.finish = FIN_DONE;
          end else if (cnt > stall_lim) begin
            busy       = 1'b0;
            cur.finish = FIN_DROP;
          end
        end

        if (64'(since_period) >= 64'(period)) begin
          src = force_pat ? SRC_PATTERN : src_sel;
          if (src == SRC_PATTERN) begin
            build_pattern(pat_sel, it.build_ok);
          end else if (src == SRC_STREAM) begin
            cnt  = 64'(since_submit);
            slim = 64'(starve_limit);
            if (!have_frame || cnt > slim) begin
              if (!starved_flag) begin
                starved_flag         = 1'b1;
                cur.starvation_event = 1'b1;
              end
              build_pattern(PAT_BLACK, it.build_ok);
            end
          end

          if (src != SRC_STREAM && src != SRC_PATTERN) begin
            cur.idle_period = 1'b1;
            since_period    = '0;
          end else if (busy) begin
            cur.late_start = 1'b1;
          end else if (!have_frame) begin
            cur.idle_period = 1'b1;
            since_period    = '0;
          end else begin
            send_idx           = ready_idx;
            since_tx           = '0;
            since_period       = '0;
            busy               = 1'b1;
            cur.frame_repeated = ~fresh;
            fresh              = 1'b0;
            cur.start_tx       = 1'b1;
          end
        end
      end
      cur.tx_buffer   = send_idx;
      cur.starved     = starved_flag;
      cur.needs_frame = en && !fresh;
      expected_results.push_back(cur);
    endfunction

    function void check_field(string name, logic [1:0] want, logic [1:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(pacing_result_t act);
      pacing_result_t want;
      if (expected_results.size() == 0) begin
        $error("result arrived with no item outstanding");
        errors++;
        return;
      end
      want = expected_results.pop_front();
      n_results++;
      if (want.start_tx) n_starts++;
      if (want.finish == FIN_DROP) n_drops++;
      if (want.late_start) n_late++;
      if (want.starvation_event) n_starve++;
      check_field("start_tx",         want.start_tx,         act.start_tx);
      check_field("tx_buffer",        want.tx_buffer,        act.tx_buffer);
      check_field("build_buffer",     want.build_buffer,     act.build_buffer);
      check_field("finish",           want.finish,           act.finish);
      check_field("late_start",       want.late_start,       act.late_start);
      check_field("frame_repeated",   want.frame_repeated,   act.frame_repeated);
      check_field("frame_superseded", want.frame_superseded, act.frame_superseded);
      check_field("starvation_event", want.starvation_event, act.starvation_event);
      check_field("starved",          want.starved,          act.starved);
      check_field("idle_period",      want.idle_period,      act.idle_period);
      check_field("build_rejected",   want.build_rejected,   act.build_rejected);
      check_field("needs_frame",      want.needs_frame,      act.needs_frame);
    endfunction
  endclass

  logic                   clk;
  logic                   rst;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  fpdbs_in_if  item_if();
  fpdbs_out_if result_if();

  pacing_scoreboard sb;

  // sender / receiver idling controls
  logic tx_steady;
  logic rx_steady;
  logic hold_request;
  int   n_settings;

  frame_pacing_double_buffer_scheduler_core u_top (
    .clk        (clk),
    .rst        (rst),
    .item_in    (item_if),
    .result_out (result_if),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    return ($urandom_range(99) < 85) ? $urandom_range(3, 1) : $urandom_range(40, 12);
  endfunction

  function automatic pacing_item_t pack_item(logic op, logic dma, logic fifo, logic ok);
    return {op, dma, fifo, ok};
  endfunction

  // Random item; done_pct biases ticks toward a finished DMA + empty FIFO
  function automatic pacing_item_t random_item(int submit_pct, int done_pct, int ok_pct);
    pacing_item_t it;
    it.operation = ($urandom_range(99) < submit_pct) ? OP_SUBMIT : OP_TICK;
    if (it.operation == OP_TICK && $urandom_range(99) < done_pct) begin
      it.dma_done   = 1'b1;
      it.fifo_empty = 1'b1;
    end else begin
      it.dma_done   = 1'($urandom_range(1));
      it.fifo_empty = 1'($urandom_range(1));
    end
    it.build_ok = ($urandom_range(99) < ok_pct);
    return it;
  endfunction

  // Offer one item, hold it until taken, then maybe leave a gap.
  // valid is only lowered when a gap follows, so back-to-back items
  // never see a lower and raise in the same step.
  task automatic send_item(pacing_item_t it);
    int gap;
    item_if.valid      <= 1'b1;
    item_if.operation  <= it.operation;
    item_if.dma_done   <= it.dma_done;
    item_if.fifo_empty <= it.fifo_empty;
    item_if.build_ok   <= it.build_ok;
    do @(posedge clk); while (!item_if.ready);
    gap = 0;
    if (!tx_steady && $urandom_range(99) < 30) gap = pick_gap();
    if (gap > 0) begin
      item_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stop offering and wait until every owed result is back; the first edge
  // lets the sampler log an item taken on the edge just passed
  task automatic settle();
    item_if.valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    sb.write_register(idx, data);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Full register set; enable goes first since disabling clears the source
  task automatic apply_setting(logic en, logic [1:0] src, logic frc, logic pat,
                               logic [PERIOD_W-1:0] per, logic [STARV_W-1:0] stv,
                               logic rearm_first);
    settle();
    if (rearm_first) write_reg(REG_ENABLED, '0);
    write_reg(REG_ENABLED, CFG_DATA_W'(en));
    write_reg(REG_SOURCE, CFG_DATA_W'(src));
    write_reg(REG_FORCE_PATTERN, CFG_DATA_W'(frc));
    write_reg(REG_PATTERN_SELECT, CFG_DATA_W'(pat));
    write_reg(REG_PERIOD_TICKS, CFG_DATA_W'(per));
    write_reg(REG_STARV_TICKS, CFG_DATA_W'(stv));
    n_settings++;
  endtask

  // Sample both channels at the edge; results first, since a result
  // always belongs to an older item than one taken on the same edge
  always @(posedge clk) begin
    if (!rst) begin
      if (result_if.valid && result_if.ready)
        sb.check_result({result_if.start_tx, result_if.tx_buffer, result_if.build_buffer,
                         result_if.finish, result_if.late_start, result_if.frame_repeated,
                         result_if.frame_superseded, result_if.starvation_event,
                         result_if.starved, result_if.idle_period,
                         result_if.build_rejected, result_if.needs_frame});
      if (item_if.valid && item_if.ready)
        sb.predict_item({item_if.operation, item_if.dma_done, item_if.fifo_empty,
                         item_if.build_ok});
    end
  end

  // Receiver: random back-pressure, steady stretches, and one long hold-off
  // on request, counted here while the sender keeps offering.
  initial begin
    int rx_gap;
    int rx_cycle;
    rx_gap    = 0;
    rx_cycle  = 0;
    rx_steady = 1'b0;
    result_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      rx_cycle++;
      if (rx_cycle % 200 == 0) rx_steady = ($urandom_range(9) < 3);
      if (rst) begin
        result_if.ready <= 1'b0;
      end else if (hold_request) begin
        result_if.ready <= 1'b0;
        repeat (LONG_HOLD - 1) @(posedge clk);
        hold_request = 1'b0;
      end else if (rx_gap > 0) begin
        result_if.ready <= 1'b0;
        rx_gap--;
      end else begin
        result_if.ready <= 1'b1;
        if (!rx_steady && $urandom_range(99) < 25) rx_gap = pick_gap();
      end
    end
  end

  // Watchdog: too long with no handshake on either side ends the run
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((item_if.valid && item_if.ready) || (result_if.valid && result_if.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("frame_pacing_double_buffer_scheduler_core regression: fail");
    $finish;
  end

  initial begin
    int                  phase_items, submit_pct, done_pct, ok_pct, pick;
    logic [PERIOD_W-1:0] per;
    logic [STARV_W-1:0]  stv;
    logic [1:0]          src;
    logic                en;

    sb           = new();
    tx_steady    = 1'b0;
    hold_request = 1'b0;
    n_settings   = 0;

    rst                <= 1'b1;
    item_if.valid      <= 1'b0;
    item_if.operation  <= OP_TICK;
    item_if.dma_done   <= 1'b0;
    item_if.fifo_empty <= 1'b0;
    item_if.build_ok   <= 1'b0;
    cfg_we             <= 1'b0;
    cfg_index          <= REG_ENABLED;
    cfg_data           <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // --- directed ---
    // disabled after reset: tick ignored, submits rejected
    send_item(pack_item(OP_TICK,   1'b1, 1'b1, 1'b1));
    send_item(pack_item(OP_SUBMIT, 1'b1, 1'b0, 1'b1));
    send_item(pack_item(OP_SUBMIT, 1'b0, 1'b1, 1'b0));

    // stream, short period: failed build, build, supersede, start, finish
    apply_setting(1'b1, SRC_STREAM, 1'b0, PAT_GRID, 30'd2, 32'd6, 1'b0);
    send_item(pack_item(OP_SUBMIT, 1'b0, 1'b0, 1'b0));
    send_item(pack_item(OP_SUBMIT, 1'b0, 1'b0, 1'b1));
    send_item(pack_item(OP_SUBMIT, 1'b1, 1'b1, 1'b1));
    send_item(pack_item(OP_TICK,   1'b0, 1'b0, 1'b1));
    send_item(pack_item(OP_TICK,   1'b0, 1'b0, 1'b1));
    send_item(pack_item(OP_TICK,   1'b1, 1'b0, 1'b1));
    send_item(pack_item(OP_TICK,   1'b0, 1'b1, 1'b1));
    send_item(pack_item(OP_TICK,   1'b1, 1'b1, 1'b1));
    // no more submits: repeated frames, then starvation and black
    repeat (2) send_item(pack_item(OP_TICK, 1'b0, 1'b0, 1'b0));
    repeat (4) send_item(pack_item(OP_TICK, 1'b0, 1'b0, 1'b1));

    // forced grid pattern: failed build, build, then held (no rebuild)
    apply_setting(1'b1, SRC_STREAM, 1'b1, PAT_GRID, 30'd1, 32'd6, 1'b0);
    send_item(pack_item(OP_TICK, 1'b1, 1'b1, 1'b0));
    send_item(pack_item(OP_TICK, 1'b1, 1'b1, 1'b1));
    send_item(pack_item(OP_TICK, 1'b1, 1'b1, 1'b1));

    // source code three acts as idle; period zero elapses every tick
    apply_setting(1'b1, SRC_UNUSED, 1'b0, PAT_GRID, 30'd0, 32'd6, 1'b0);
    repeat (2) send_item(pack_item(OP_TICK, 1'b0, 1'b0, 1'b1));

    // re-arm through a disable, black pattern with period zero
    apply_setting(1'b1, SRC_PATTERN, 1'b0, PAT_BLACK, 30'd0, 32'd1, 1'b1);
    repeat (3) send_item(pack_item(OP_TICK, 1'b1, 1'b1, 1'b1));

    // --- random phases ---
    for (int p = 0; p < N_PHASES; p++) begin
      if (p == 1)
        per = '0;
      else if (p == 2)
        per = '1;
      else if ($urandom_range(3) == 0)
        per = PERIOD_W'($urandom_range(40, 9));
      else
        per = PERIOD_W'($urandom_range(8, 1));

      if (p == 2)
        stv = '1;
      else if (p == 3)
        stv = 32'd1;
      else
        stv = STARV_W'($urandom_range(60, 1));

      pick = $urandom_range(9);
      if (pick == 0)
        src = SRC_IDLE;
      else if (pick == 1)
        src = SRC_UNUSED;
      else if (pick < 6)
        src = SRC_STREAM;
      else
        src = SRC_PATTERN;

      en = (p != 5);
      apply_setting(en, src, ($urandom_range(4) == 0), 1'($urandom_range(1)), per, stv,
                    ($urandom_range(2) == 0));

      tx_steady   = ($urandom_range(3) == 0);
      submit_pct  = $urandom_range(45, 10);
      done_pct    = $urandom_range(85, 15);
      ok_pct      = $urandom_range(95, 70);
      phase_items = (p == 5) ? 40 : 145;

      for (int i = 0; i < phase_items; i++) begin
        // long receiver hold-off while items keep coming
        if (p == 7 && i == 60) hold_request = 1'b1;
        // sender waits until everything owed has come back
        if (p == 9 && i == 70) settle();
        send_item(random_item(submit_pct, done_pct, ok_pct));
      end
    end

    settle();
    repeat (8) @(posedge clk);

    $display("Checked %0d results for %0d items over %0d register settings.",
             sb.n_results, sb.n_items, n_settings);
    $display("Saw %0d transfer starts, %0d stall drops, %0d late starts, %0d starvations.",
             sb.n_starts, sb.n_drops, sb.n_late, sb.n_starve);
    if (sb.errors == 0 && sb.expected_results.size() == 0) begin
      $display("frame_pacing_double_buffer_scheduler_core regression: pass");
    end else begin
      $display("frame_pacing_double_buffer_scheduler_core regression: fail");
    end
    $finish;
  end

endmodule
